FILE: hw/rtl/tpd_pkg.sv
package tpd_pkg;

    localparam int PAD_COUNT_DEF = 10;
    localparam int PAD_COUNT_MAX = 16;

    localparam int PAD_IDX_W = 4;
    localparam int READING_W = 8;
    localparam int RUN_W     = 8;
    localparam int STATES_W  = 10;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TOUCH_THRESHOLD = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STABLE_COUNT    = 4'd1;

    localparam logic [READING_W-1:0] TOUCH_THRESHOLD_RST = 8'd128;
    localparam logic [RUN_W-1:0]     STABLE_COUNT_RST    = 8'd3;

    typedef struct packed {
        logic [PAD_IDX_W-1:0] pad_index;
        logic [READING_W-1:0] reading_value;
        logic                 scan_end;
    } in_word_t;

    typedef struct packed {
        logic [STATES_W-1:0] pad_states;
        logic                pad_on;
    } out_word_t;

    // One reading handed from the input register to the pad bank.
    typedef struct packed {
        logic                 fire;
        logic [PAD_IDX_W-1:0] pad_index;
        logic [READING_W-1:0] reading_value;
        logic                 scan_end;
    } pad_req_t;

    typedef struct packed {
        logic [READING_W-1:0] touch_threshold;
        logic [RUN_W-1:0]     stable_count;
    } pad_cfg_t;

endpackage

FILE: hw/rtl/tpd_pad_bank.sv
module tpd_pad_bank #(
    parameter int PAD_COUNT = tpd_pkg::PAD_COUNT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  tpd_pkg::pad_req_t  req,
    input  tpd_pkg::pad_cfg_t  cfg,
    output tpd_pkg::out_word_t result
);

    localparam int SEL_W = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;

    logic [tpd_pkg::RUN_W-1:0] touched_run_reg   [PAD_COUNT];
    logic [tpd_pkg::RUN_W-1:0] untouched_run_reg [PAD_COUNT];
    logic [PAD_COUNT-1:0]      state_bits_reg;
    logic [PAD_COUNT-1:0]      state_bits_next;
    logic                      primed_reg;
    logic                      primed_next;

    logic                                 pad_known;
    logic                                 touched;
    logic                                 update;
    logic [SEL_W-1:0]                     sel;
    logic [tpd_pkg::RUN_W-1:0]            touched_cur;
    logic [tpd_pkg::RUN_W-1:0]            untouched_cur;
    logic [tpd_pkg::RUN_W-1:0]            touched_next;
    logic [tpd_pkg::RUN_W-1:0]            untouched_next;
    logic [tpd_pkg::PAD_COUNT_MAX-1:0]    states_wide;

    assign pad_known = {1'b0, req.pad_index} < (tpd_pkg::PAD_IDX_W + 1)'(PAD_COUNT);
    assign sel       = req.pad_index[SEL_W-1:0];
    assign touched   = req.reading_value < cfg.touch_threshold;
    // Readings of the first scan after reset leave the pads alone.
    assign update    = req.fire && pad_known && primed_reg;

    assign touched_cur   = touched_run_reg[sel];
    assign untouched_cur = untouched_run_reg[sel];

    always_comb
    begin
        touched_next    = touched_cur;
        untouched_next  = untouched_cur;
        state_bits_next = state_bits_reg;
        if (update)
        begin
            if (touched)
            begin
                untouched_next = '0;
                if (touched_cur < cfg.stable_count)
                begin
                    touched_next = touched_cur + 1'b1;
                end
                else
                begin
                    state_bits_next[sel] = 1'b1;
                end
            end
            else
            begin
                touched_next = '0;
                if (untouched_cur < cfg.stable_count)
                begin
                    untouched_next = untouched_cur + 1'b1;
                end
                else
                begin
                    state_bits_next[sel] = 1'b0;
                end
            end
        end
    end

    assign primed_next = primed_reg || (req.fire && req.scan_end);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PAD_COUNT; i++)
            begin
                touched_run_reg[i]   <= '0;
                untouched_run_reg[i] <= '0;
            end
            state_bits_reg <= '0;
            primed_reg     <= 1'b0;
        end
        else
        begin
            if (update)
            begin
                touched_run_reg[sel]   <= touched_next;
                untouched_run_reg[sel] <= untouched_next;
            end
            state_bits_reg <= state_bits_next;
            primed_reg     <= primed_next;
        end
    end

    // The result shows the states as they stand after this reading.
    assign states_wide       = tpd_pkg::PAD_COUNT_MAX'(state_bits_next);
    assign result.pad_states = states_wide[tpd_pkg::STATES_W-1:0];
    assign result.pad_on     = pad_known && states_wide[req.pad_index];

endmodule

FILE: hw/rtl/touch_pad_threshold_debouncer_top.sv
// Touch pad debouncer: one capacitance reading word in, one result word out.
// Each input word names a pad, carries its 8-bit reading and marks the last
// reading of a scan. A reading below the threshold counts as touched; a pad
// changes state once enough like readings have been seen in a row.
// Every input word gives exactly one output word with all pad states and the
// state of the pad just read.
// An accepted word sits in the input register; the pad update then writes the
// result register once the output side is free, else the word waits there.
// Throughput is one word per cycle while out_ready stays high; the pad update
// is a single compare and counter step between the input and result registers.
// The configuration channel is always ready; index 0 is the touch threshold,
// index 1 the stable count, other indexes are ignored.
// Reset clears all run counters and states, restores the threshold to 128 and
// the stable count to 3, and arms the first-scan discard: readings up to and
// including the first end-of-scan word change nothing.
// When the receiver stalls, the result register holds its word, the input
// register fills, and in_ready then drops until out_ready returns.
module touch_pad_threshold_debouncer_top #(
    parameter int PAD_COUNT = tpd_pkg::PAD_COUNT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  tpd_pkg::in_word_t                 in_word,
    output logic                              out_valid,
    input  logic                              out_ready,
    output tpd_pkg::out_word_t                out_word,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tpd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tpd_pkg::CFG_DATA_W-1:0]    cfg_data
);

    tpd_pkg::in_word_t  in_word_reg;
    logic               in_valid_reg;
    tpd_pkg::out_word_t out_word_reg;
    logic               out_valid_reg;
    tpd_pkg::pad_cfg_t  cfg_reg;
    tpd_pkg::pad_req_t  req;
    tpd_pkg::out_word_t result;
    logic               advance;

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign req.fire          = advance;
    assign req.pad_index     = in_word_reg.pad_index;
    assign req.reading_value = in_word_reg.reading_value;
    assign req.scan_end      = in_word_reg.scan_end;

    tpd_pad_bank #(
        .PAD_COUNT(PAD_COUNT)
    ) u_bank (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .cfg    (cfg_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.touch_threshold <= tpd_pkg::TOUCH_THRESHOLD_RST;
            cfg_reg.stable_count    <= tpd_pkg::STABLE_COUNT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                tpd_pkg::CFG_TOUCH_THRESHOLD: cfg_reg.touch_threshold <= cfg_data;
                tpd_pkg::CFG_STABLE_COUNT:    cfg_reg.stable_count    <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_word_reg <= in_word;
        end
        if (advance)
        begin
            out_word_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

FILE: hw/rtl/tpd_checker.sv
module tpd_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input tpd_pkg::in_word_t              in_word,
    input logic                           out_valid,
    input logic                           out_ready,
    input tpd_pkg::out_word_t             out_word
);

    // A stalled result word must be held unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_word))
        else $error("result word changed or dropped while stalled");

    // After an accepted word, out_valid is high once the word has passed the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> ##1 out_valid)
        else $error("accepted word did not reach the output in time");

    // The input side only backs off while the output side is stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input not ready although the output is free");

    // With no input arriving and the receiver ready, the output drains.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!in_valid && out_ready) [*3] |-> !out_valid)
        else $error("result word appeared without an input word");

    // A waiting input word is held unchanged until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_word))
        else $error("input word changed or dropped while waiting");

endmodule

bind touch_pad_threshold_debouncer_top tpd_checker u_tpd_checker (.*);

FILE: verif/touch_pad_threshold_debouncer_top_test.sv
module touch_pad_threshold_debouncer_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    import tpd_pkg::*;

    localparam int PAD_COUNT = PAD_COUNT_DEF;
    localparam int IN_WORD_W = $bits(in_word_t);
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LAST = '1;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    in_word_t              in_word = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_word_t             out_word;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Debounce state as the block should hold it.
    logic [READING_W-1:0]  thr_model = TOUCH_THRESHOLD_RST;
    logic [RUN_W-1:0]      stable_model = STABLE_COUNT_RST;
    logic [RUN_W-1:0]      touched_run [PAD_COUNT];
    logic [RUN_W-1:0]      untouched_run [PAD_COUNT];
    logic [PAD_COUNT-1:0]  state_bits = '0;
    logic                  primed = 1'b0;

    in_word_t              pending_readings [$];
    out_word_t             predicted_states [$];
    logic                  pad_pressed [PAD_COUNT];
    int                    tx_idle_pct = 0;
    int                    rx_stall_pct = 0;
    int                    mismatch_count = 0;

    touch_pad_threshold_debouncer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic out_word_t debounce_reading(input in_word_t w);
        out_word_t r;
        logic      hit;
        hit = w.pad_index < PAD_COUNT;
        if (hit && primed)
        begin
            if (w.reading_value < thr_model)
            begin
                untouched_run[w.pad_index] = '0;
                if (touched_run[w.pad_index] < stable_model)
                    touched_run[w.pad_index] = touched_run[w.pad_index] + 1'b1;
                else
                    state_bits[w.pad_index] = 1'b1;
            end
            else
            begin
                touched_run[w.pad_index] = '0;
                if (untouched_run[w.pad_index] < stable_model)
                    untouched_run[w.pad_index] = untouched_run[w.pad_index] + 1'b1;
                else
                    state_bits[w.pad_index] = 1'b0;
            end
        end
        if (w.scan_end)
            primed = 1'b1;
        r.pad_states = state_bits;
        r.pad_on = hit ? state_bits[w.pad_index] : 1'b0;
        return r;
    endfunction

    // Sender: a word is predicted at the edge where it is accepted.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_word <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                predicted_states.push_back(debounce_reading(in_word));
            if (!in_valid || in_ready)
            begin
                if (pending_readings.size() != 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_word <= pending_readings.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (predicted_states.size() == 0)
            begin
                $display("%0t: result word %h arrived with nothing expected", $time, out_word);
                mismatch_count++;
            end
            else
            begin
                if (out_word.pad_states !== predicted_states[0].pad_states)
                begin
                    $display("%0t: pad_states expected %h got %h", $time,
                             predicted_states[0].pad_states, out_word.pad_states);
                    mismatch_count++;
                end
                if (out_word.pad_on !== predicted_states[0].pad_on)
                begin
                    $display("%0t: pad_on expected %b got %b", $time,
                             predicted_states[0].pad_on, out_word.pad_on);
                    mismatch_count++;
                end
                void'(predicted_states.pop_front());
            end
        end
    end

    task automatic queue_reading(input int pad, input int value, input bit last);
        in_word_t w;
        w.pad_index = PAD_IDX_W'(pad);
        w.reading_value = READING_W'(value);
        w.scan_end = last;
        pending_readings.push_back(w);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_readings.size() != 0 || in_valid || predicted_states.size() != 0);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_TOUCH_THRESHOLD)
            thr_model = value;
        else if (idx == CFG_STABLE_COUNT)
            stable_model = value;
    endtask

    // Waits until every outstanding word has come back before writing the registers.
    task automatic reconfigure(input int thr, input int stable, input int tx, input int rx);
        wait_drained();
        write_register(CFG_TOUCH_THRESHOLD, CFG_DATA_W'(thr));
        write_register(CFG_STABLE_COUNT, CFG_DATA_W'(stable));
        write_register(CFG_IDX_W'($urandom_range(CFG_UNUSED_LAST, CFG_STABLE_COUNT + 1)),
                       CFG_DATA_W'($urandom));
        tx_idle_pct = tx;
        rx_stall_pct = rx;
    endtask

    // Mostly whole or partial scans with each pad held touched or untouched for
    // a while, so that the run counters reach the stable count; the rest is noise.
    task automatic queue_random_scans(input int count);
        int pushed;
        int p;
        int first;
        int thr;
        int value;
        in_word_t w;
        pushed = 0;
        thr = int'(thr_model);
        while (pushed < count)
        begin
            if ($urandom_range(9) == 0)
            begin
                w = IN_WORD_W'($urandom);
                pending_readings.push_back(w);
                if (w.pad_index < PAD_COUNT)
                    pushed++;
            end
            else
            begin
                first = ($urandom_range(3) == 0) ? $urandom_range(PAD_COUNT - 1) : 0;
                for (p = first; p < PAD_COUNT; p++)
                begin
                    if ($urandom_range(7) == 0)
                        pad_pressed[p] = ~pad_pressed[p];
                    if ($urandom_range(3) == 0)
                        value = (pad_pressed[p] && thr != 0) ? thr - 1 : thr;
                    else if (pad_pressed[p] && thr != 0)
                        value = $urandom_range(thr - 1, 0);
                    else
                        value = $urandom_range(255, thr);
                    queue_reading(p, value, p == PAD_COUNT - 1);
                    pushed++;
                end
            end
        end
    endtask

    initial
    begin
        int p;
        for (p = 0; p < PAD_COUNT; p++)
        begin
            touched_run[p] = '0;
            untouched_run[p] = '0;
            pad_pressed[p] = 1'b0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // The whole first scan is discarded, including an out-of-range pad.
        queue_reading(15, 255, 1'b0);
        for (p = 0; p < PAD_COUNT; p++)
            queue_reading(p, 0, p == PAD_COUNT - 1);
        // With the reset stable count, the fourth touched reading sets the pad.
        repeat (4) queue_reading(0, 0, 1'b0);
        repeat (4) queue_reading(PAD_COUNT - 1, 127, 1'b0);
        queue_reading(0, 128, 1'b0);
        queue_reading(PAD_COUNT, 0, 1'b0);
        queue_reading(15, 255, 1'b1);
        wait_drained();
        write_register(CFG_UNUSED_LAST, '1);
        queue_random_scans(90);

        // A stable count of zero flips a pad on the first like reading.
        reconfigure(255, 0, 63, 0);
        queue_reading(3, 254, 1'b0);
        queue_reading(3, 255, 1'b1);
        queue_random_scans(80);

        reconfigure(0, 255, 0, 63);
        queue_random_scans(60);

        reconfigure($urandom_range(255), $urandom_range(5, 1), 6, 6);
        queue_random_scans(100);

        reconfigure($urandom_range(254, 1), 2, 0, 0);
        queue_random_scans(80);

        reconfigure(int'(TOUCH_THRESHOLD_RST), int'(STABLE_COUNT_RST), 6, 6);
        queue_random_scans(90);

        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && predicted_states.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: touch_pad_threshold_debouncer_top.f
hw/rtl/tpd_pkg.sv
hw/rtl/tpd_pad_bank.sv
hw/rtl/touch_pad_threshold_debouncer_top.sv
hw/rtl/tpd_checker.sv
verif/touch_pad_threshold_debouncer_top_test.sv
